// ===== design/rvcc_pkg.sv =====
// Shared widths, channel numbers, constants, stage payload types and helpers.
package rvcc_pkg;

   localparam int CH_W      = 4;
   localparam int MV_IN_W   = 16;
   localparam int CODE_W    = 7;
   localparam int LOW_W     = 5;
   localparam int MV_W      = 13;
   localparam int OPND_W    = 12;
   localparam int MULT_W    = 15;
   localparam int PROD_W    = OPND_W + MULT_W;
   localparam int DIV_SHIFT = 18;

   localparam logic [CH_W-1:0] CH_BUCK1 = 4'd0;
   localparam logic [CH_W-1:0] CH_BUCK2 = 4'd1;
   localparam logic [CH_W-1:0] CH_BUCK3 = 4'd2;
   localparam logic [CH_W-1:0] CH_BUCK4 = 4'd3;
   localparam logic [CH_W-1:0] CH_BUCK5 = 4'd4;
   localparam logic [CH_W-1:0] CH_LDOA1 = 4'd5;
   localparam logic [CH_W-1:0] CH_LDOA2 = 4'd6;
   localparam logic [CH_W-1:0] CH_LDOA3 = 4'd7;
   localparam logic [CH_W-1:0] CH_LDOA4 = 4'd8;
   localparam logic [CH_W-1:0] CH_LDOB1 = 4'd9;
   localparam logic [CH_W-1:0] CH_LDOB2 = 4'd10;
   localparam logic [CH_W-1:0] CH_CPUS  = 4'd11;
   localparam logic [CH_W-1:0] CH_LDOD1 = 4'd12;
   localparam logic [CH_W-1:0] CH_LDOD2 = 4'd13;

   localparam logic [LOW_W-1:0]  CODE_BUCK5_1200 = 5'h19;
   localparam logic [CODE_W-1:0] CODE_SEG2_BASE  = 7'd71;
   localparam logic [CODE_W-1:0] CODE_SEG3_BASE  = 7'd88;

   // ceil(2^DIV_SHIFT / d): exact truncating quotient for any OPND_W-bit dividend
   localparam logic [MULT_W-1:0] RECIP_10  = MULT_W'(((1 << DIV_SHIFT) + 9) / 10);
   localparam logic [MULT_W-1:0] RECIP_20  = MULT_W'(((1 << DIV_SHIFT) + 19) / 20);
   localparam logic [MULT_W-1:0] RECIP_50  = MULT_W'(((1 << DIV_SHIFT) + 49) / 50);
   localparam logic [MULT_W-1:0] RECIP_100 = MULT_W'(((1 << DIV_SHIFT) + 99) / 100);

   localparam logic [MULT_W-1:0] STEP_10  = MULT_W'(10);
   localparam logic [MULT_W-1:0] STEP_20  = MULT_W'(20);
   localparam logic [MULT_W-1:0] STEP_50  = MULT_W'(50);
   localparam logic [MULT_W-1:0] STEP_100 = MULT_W'(100);

   typedef struct packed {
      logic              decode;
      logic              ok;
      logic              wide;
      logic [OPND_W-1:0] operand;
      logic [MULT_W-1:0] factor;
      logic [MV_W-1:0]   base;
   } operand_type;

   typedef struct packed {
      logic              decode;
      logic              ok;
      logic              wide;
      logic [PROD_W-1:0] product;
      logic [MV_W-1:0]   base;
   } product_type;

   function automatic logic [OPND_W-1:0] clamp_offset(
      input logic [MV_IN_W-1:0] mv,
      input logic [MV_IN_W-1:0] lo,
      input logic [MV_IN_W-1:0] hi
   );
      logic [MV_IN_W-1:0] v;
      logic [MV_IN_W-1:0] d;
      begin
         if (mv < lo) begin
            v = lo;
         end else if (mv > hi) begin
            v = hi;
         end else begin
            v = mv;
         end
         d = v - lo;
         return d[OPND_W-1:0];
      end
   endfunction

endpackage

// ===== design/rvcc_classify.sv =====
// First stage: channel and segment selection, offset, factor and base registers.
module rvcc_classify (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_mode,
   input  logic [rvcc_pkg::CH_W-1:0]     in_channel,
   input  logic [rvcc_pkg::MV_IN_W-1:0]  in_millivolts,
   input  logic [rvcc_pkg::CODE_W-1:0]   in_code,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rvcc_pkg::operand_type         out_data
);

   logic                  valid_ff;
   logic                  valid_in;
   rvcc_pkg::operand_type data_ff;
   rvcc_pkg::operand_type data_in;

   always_comb begin
      logic [rvcc_pkg::MV_IN_W-1:0] mv;
      logic [rvcc_pkg::CODE_W-1:0]  c;
      logic [rvcc_pkg::LOW_W-1:0]   low;
      logic [rvcc_pkg::MV_IN_W-1:0] seg2_hi;
      logic [rvcc_pkg::CODE_W-1:0]  c_seg2;
      logic [rvcc_pkg::CODE_W-1:0]  c_seg3;
      logic [rvcc_pkg::MV_IN_W-1:0] d_seg1;
      logic [rvcc_pkg::MV_IN_W-1:0] d_seg2;
      logic [rvcc_pkg::MV_IN_W-1:0] d_seg3;
      mv      = in_millivolts;
      c       = in_code;
      low     = c[rvcc_pkg::LOW_W-1:0];
      seg2_hi = (in_channel == rvcc_pkg::CH_BUCK4) ? 16'd1840 : 16'd1540;
      c_seg2  = c - rvcc_pkg::CODE_SEG2_BASE;
      c_seg3  = c - rvcc_pkg::CODE_SEG3_BASE;
      d_seg1  = mv - 16'd500;
      d_seg2  = mv - 16'd1220;
      d_seg3  = mv - 16'd1600;
      data_in         = '0;
      data_in.decode  = in_mode;
      data_in.ok      = 1'b1;
      data_in.factor  = rvcc_pkg::RECIP_100;
      if (!in_mode) begin
         unique case (in_channel)
            rvcc_pkg::CH_BUCK1: begin
               data_in.operand = rvcc_pkg::clamp_offset(mv, 16'd1500, 16'd3400);
            end
            rvcc_pkg::CH_BUCK2, rvcc_pkg::CH_BUCK3, rvcc_pkg::CH_BUCK4: begin
               data_in.wide = 1'b1;
               priority if (mv >= 16'd500 && mv <= 16'd1200) begin
                  data_in.operand = d_seg1[rvcc_pkg::OPND_W-1:0];
                  data_in.factor  = rvcc_pkg::RECIP_10;
               end else if (mv >= 16'd1220 && mv <= seg2_hi) begin
                  data_in.operand = d_seg2[rvcc_pkg::OPND_W-1:0];
                  data_in.factor  = rvcc_pkg::RECIP_20;
                  data_in.base    = rvcc_pkg::MV_W'(rvcc_pkg::CODE_SEG2_BASE);
               end else if (in_channel == rvcc_pkg::CH_BUCK3 && mv >= 16'd1600
                            && mv <= 16'd3400) begin
                  data_in.operand = d_seg3[rvcc_pkg::OPND_W-1:0];
                  data_in.base    = rvcc_pkg::MV_W'(rvcc_pkg::CODE_SEG3_BASE);
               end else begin
                  data_in.ok = 1'b0;
               end
            end
            rvcc_pkg::CH_BUCK5: begin
               if (mv == 16'd1200) begin
                  data_in.base = rvcc_pkg::MV_W'(rvcc_pkg::CODE_BUCK5_1200);
               end else begin
                  data_in.operand = rvcc_pkg::clamp_offset(mv, 16'd1400, 16'd3700);
               end
            end
            rvcc_pkg::CH_LDOA1, rvcc_pkg::CH_LDOA2, rvcc_pkg::CH_LDOA3,
            rvcc_pkg::CH_LDOA4, rvcc_pkg::CH_LDOB1, rvcc_pkg::CH_LDOB2: begin
               data_in.operand = rvcc_pkg::clamp_offset(mv, 16'd500, 16'd3500);
            end
            rvcc_pkg::CH_CPUS, rvcc_pkg::CH_LDOD2: begin
               data_in.operand = rvcc_pkg::clamp_offset(mv, 16'd500, 16'd1400);
               data_in.factor  = rvcc_pkg::RECIP_50;
            end
            rvcc_pkg::CH_LDOD1: begin
               data_in.operand = rvcc_pkg::clamp_offset(mv, 16'd500, 16'd3300);
            end
            default: begin
               data_in.ok = 1'b0;
            end
         endcase
      end else begin
         data_in.operand = rvcc_pkg::OPND_W'(low);
         data_in.factor  = rvcc_pkg::STEP_100;
         unique case (in_channel)
            rvcc_pkg::CH_BUCK1: begin
               data_in.base = 13'd1500;
            end
            rvcc_pkg::CH_BUCK2, rvcc_pkg::CH_BUCK3, rvcc_pkg::CH_BUCK4: begin
               priority if (c < rvcc_pkg::CODE_SEG2_BASE) begin
                  data_in.operand = rvcc_pkg::OPND_W'(c);
                  data_in.factor  = rvcc_pkg::STEP_10;
                  data_in.base    = 13'd500;
               end else if (in_channel == rvcc_pkg::CH_BUCK3
                            && c >= rvcc_pkg::CODE_SEG3_BASE) begin
                  data_in.operand = rvcc_pkg::OPND_W'(c_seg3);
                  data_in.base    = 13'd1600;
               end else begin
                  data_in.operand = rvcc_pkg::OPND_W'(c_seg2);
                  data_in.factor  = rvcc_pkg::STEP_20;
                  data_in.base    = 13'd1220;
               end
            end
            rvcc_pkg::CH_BUCK5: begin
               if (low == rvcc_pkg::CODE_BUCK5_1200) begin
                  data_in.operand = '0;
                  data_in.base    = 13'd1200;
               end else begin
                  data_in.base = 13'd1400;
               end
            end
            rvcc_pkg::CH_CPUS, rvcc_pkg::CH_LDOD2: begin
               data_in.factor = rvcc_pkg::STEP_50;
               data_in.base   = 13'd500;
            end
            rvcc_pkg::CH_LDOA1, rvcc_pkg::CH_LDOA2, rvcc_pkg::CH_LDOA3,
            rvcc_pkg::CH_LDOA4, rvcc_pkg::CH_LDOB1, rvcc_pkg::CH_LDOB2,
            rvcc_pkg::CH_LDOD1: begin
               data_in.base = 13'd500;
            end
            default: begin
               data_in.ok      = 1'b0;
               data_in.operand = '0;
            end
         endcase
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/rvcc_scale.sv =====
// Second stage: multiply the operand by the step or reciprocal factor.
module rvcc_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rvcc_pkg::operand_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rvcc_pkg::product_type out_data
);

   logic                  valid_ff;
   logic                  valid_in;
   rvcc_pkg::product_type data_ff;
   rvcc_pkg::product_type data_in;

   always_comb begin
      data_in.decode  = in_data.decode;
      data_in.ok      = in_data.ok;
      data_in.wide    = in_data.wide;
      data_in.base    = in_data.base;
      data_in.product = rvcc_pkg::PROD_W'(in_data.operand) * rvcc_pkg::PROD_W'(in_data.factor);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/rvcc_format.sv =====
// Third stage: quotient or voltage sum, field gating and the result register.
module rvcc_format (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rvcc_pkg::product_type         in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_ok,
   output logic [rvcc_pkg::CODE_W-1:0]   out_code,
   output logic                          out_wide,
   output logic [rvcc_pkg::MV_W-1:0]     out_millivolts
);

   logic                          valid_ff;
   logic                          valid_in;
   logic                          ok_ff;
   logic                          ok_in;
   logic [rvcc_pkg::CODE_W-1:0]   code_ff;
   logic [rvcc_pkg::CODE_W-1:0]   code_in;
   logic                          wide_ff;
   logic                          wide_in;
   logic [rvcc_pkg::MV_W-1:0]     mv_ff;
   logic [rvcc_pkg::MV_W-1:0]     mv_in;

   always_comb begin
      logic [rvcc_pkg::CODE_W-1:0] quotient;
      logic [rvcc_pkg::CODE_W-1:0] code_sum;
      logic [rvcc_pkg::MV_W-1:0]   mv_sum;
      quotient = in_data.product[rvcc_pkg::DIV_SHIFT +: rvcc_pkg::CODE_W];
      code_sum = quotient + in_data.base[rvcc_pkg::CODE_W-1:0];
      mv_sum   = in_data.product[rvcc_pkg::MV_W-1:0] + in_data.base;
      ok_in    = in_data.ok;
      if (in_data.decode) begin
         code_in = '0;
         wide_in = 1'b0;
         mv_in   = in_data.ok ? mv_sum : '0;
      end else begin
         code_in = in_data.ok ? code_sum : '0;
         wide_in = in_data.wide;
         mv_in   = '0;
      end
   end

   assign in_ready       = !valid_ff || out_ready;
   assign valid_in       = in_ready ? in_valid : valid_ff;
   assign out_valid      = valid_ff;
   assign out_ok         = ok_ff;
   assign out_code       = code_ff;
   assign out_wide       = wide_ff;
   assign out_millivolts = mv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ok_ff   <= ok_in;
         code_ff <= code_in;
         wide_ff <= wide_in;
         mv_ff   <= mv_in;
      end
   end

endmodule

// ===== design/regulator_voltage_code_convert_unit.sv =====
// Top level of the regulator millivolt / voltage code converter pipeline.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  mode, channel, millivolts, code_in
//   rsp      out        rsp_valid/rsp_ready  ok, code_out, wide_code, millivolts_out
//
// Three register stages: segment selection, one 12x15 multiply, add and format.
// rsp_valid rises once a taken req beat has passed the classify, scale and format
// registers; one beat per cycle is sustained while rsp_ready stays high.
// Each stage holds its beat while the stage after it is full and stalled; no beat is
// dropped or repeated, and req_ready falls only when all three stages are full.
// Synchronous reset clears the stage valid bits only.
module regulator_voltage_code_convert_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [rvcc_pkg::CH_W-1:0]     req_channel,
   input  logic [rvcc_pkg::MV_IN_W-1:0]  req_millivolts,
   input  logic [rvcc_pkg::CODE_W-1:0]   req_code_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic [rvcc_pkg::CODE_W-1:0]   rsp_code_out,
   output logic                          rsp_wide_code,
   output logic [rvcc_pkg::MV_W-1:0]     rsp_millivolts_out
);

   logic                  s1_valid;
   logic                  s1_ready;
   rvcc_pkg::operand_type s1_data;
   logic                  s2_valid;
   logic                  s2_ready;
   rvcc_pkg::product_type s2_data;

   rvcc_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_mode       (req_mode),
      .in_channel    (req_channel),
      .in_millivolts (req_millivolts),
      .in_code       (req_code_in),
      .out_valid     (s1_valid),
      .out_ready     (s1_ready),
      .out_data      (s1_data)
   );

   rvcc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   rvcc_format u_format (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s2_valid),
      .in_ready       (s2_ready),
      .in_data        (s2_data),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_ok         (rsp_ok),
      .out_code       (rsp_code_out),
      .out_wide       (rsp_wide_code),
      .out_millivolts (rsp_millivolts_out)
   );

endmodule
